// ----- src/dtt_pkg.sv -----
// shared types and constants of the delimited text tokenizer
package dtt_pkg;

  localparam int ROW_W       = 32;
  localparam int COLUMN_W    = 16;
  localparam int ROW_BITS_DEF    = 32;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [APB_ADDR_W-1:0] REG_START_ROW = 3'd0;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOI  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                cell_end;
    logic                row_end;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
  } tok_res_t;

  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] value;
  } row_load_t;

endpackage

// ----- src/dtt_if.sv -----
// item channels of the tokenizer
interface dtt_in_if;
  import dtt_pkg::*;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;
  modport source (output valid, cmd, in_byte, input ready);
  modport sink   (input valid, cmd, in_byte, output ready);
endinterface

interface dtt_out_if;
  import dtt_pkg::*;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic                byte_valid;
  logic                cell_end;
  logic                row_end;
  logic [ROW_W-1:0]    row;
  logic [COLUMN_W-1:0] column;
  modport source (output valid, out_byte, byte_valid, cell_end, row_end, row, column,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, cell_end, row_end, row, column,
                  output ready);
endinterface

// ----- src/dtt_cfg.sv -----
// apb register for the start row, with saturated row load
module dtt_cfg import dtt_pkg::*; #(
  parameter int ROW_BITS = ROW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output row_load_t             row_load
);

  localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

  logic [APB_DATA_W-1:0] start_row;
  logic                  wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_START_ROW[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row <= APB_DATA_W'(1);
    end else if (wr_hit) begin
      start_row <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_START_ROW[APB_ADDR_W-1:2]) begin
      prdata = start_row;
    end
  end

  assign row_load.load  = wr_hit;
  assign row_load.value = (pwdata > APB_DATA_W'(ROW_MAX)) ? ROW_W'(ROW_MAX) : ROW_W'(pwdata);

endmodule

// ----- src/dtt_parser.sv -----
// tokenizer state and per-byte next-state and result logic
module dtt_parser import dtt_pkg::*; #(
  parameter int ROW_BITS    = ROW_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       cmd,
  input  logic [7:0] in_byte,
  input  row_load_t  row_load,
  output logic       emit,
  output tok_res_t   res
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SKIP   = 3'd1,
    MODE_FIELD  = 3'd2,
    MODE_QUOTED = 3'd3,
    MODE_AFTER  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CONTENT,
    ACT_CELL,
    ACT_ROW
  } act_t;

  localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  mode_t                  mode, mode_next;
  logic                   quote_single, quote_single_next;
  logic [7:0]             delim, delim_next;
  logic                   has_data, has_data_next;
  logic [COLUMN_BITS-1:0] col_count, col_count_next;
  logic [ROW_BITS-1:0]    row_count, row_count_next;

  act_t       act;
  logic       h_eff;
  logic       go_field;
  logic       cand;
  logic [7:0] delim_eff;
  logic [7:0] quote_ch;

  assign cand      = (in_byte == CH_COMMA) || (in_byte == CH_TAB) || (in_byte == CH_BAR);
  assign delim_eff = ((delim == CH_NUL) && cand) ? in_byte : delim;
  assign quote_ch  = quote_single ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    delim_next        = delim;
    has_data_next     = has_data;
    act               = ACT_NONE;
    h_eff             = has_data;
    go_field          = 1'b0;

    if (cmd == CMD_EOI) begin
      if (mode == MODE_FIELD || mode == MODE_QUOTED || mode == MODE_AFTER) begin
        act = ACT_ROW;
      end else begin
        mode_next     = MODE_IDLE;
        has_data_next = 1'b0;
      end
    end else begin
      unique case (mode)
        MODE_SKIP: begin
          if (in_byte == CH_LF) mode_next = MODE_IDLE;
        end
        MODE_FIELD: begin
          go_field = 1'b1;
        end
        MODE_QUOTED: begin
          if (in_byte == CH_CR) begin
            act = ACT_NONE;
          end else if (in_byte == quote_ch) begin
            mode_next = MODE_AFTER;
          end else begin
            act = ACT_CONTENT;
          end
        end
        MODE_AFTER: begin
          if (in_byte == CH_CR) begin
            act = ACT_NONE;
          end else if ((delim == CH_NUL) && cand) begin
            delim_next = in_byte;
            act        = ACT_CELL;
          end else if (in_byte == CH_LF) begin
            act = ACT_ROW;
          end else if ((delim != CH_NUL) && (in_byte == delim)) begin
            act = ACT_CELL;
          end else begin
            mode_next = MODE_QUOTED;
            act       = ACT_CONTENT;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          if (in_byte == CH_CR || in_byte == CH_LF) begin
            act = ACT_NONE;
          end else if (in_byte == CH_NUL) begin
            mode_next = MODE_SKIP;
          end else begin
            h_eff         = 1'b0;
            has_data_next = 1'b0;
            go_field      = 1'b1;
          end
        end
      endcase

      if (go_field) begin
        mode_next = MODE_FIELD;
        if (in_byte == CH_CR) begin
          act = ACT_NONE;
        end else if ((in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) && !h_eff) begin
          quote_single_next = (in_byte == CH_SQUOTE);
          mode_next         = MODE_QUOTED;
        end else begin
          delim_next = delim_eff;
          if ((delim_eff != CH_NUL) && (in_byte == delim_eff)) begin
            act = ACT_CELL;
          end else if (in_byte == CH_LF) begin
            act = ACT_ROW;
          end else begin
            act = ACT_CONTENT;
          end
        end
      end
    end

    col_count_next = col_count;
    row_count_next = row_count;
    emit           = 1'b0;
    res.out_byte   = '0;
    res.byte_valid = 1'b0;
    res.cell_end   = 1'b0;
    res.row_end    = 1'b0;
    res.row        = ROW_W'(row_count);
    res.column     = COLUMN_W'(col_count);

    unique case (act)
      ACT_CONTENT: begin
        emit           = 1'b1;
        has_data_next  = 1'b1;
        res.out_byte   = in_byte;
        res.byte_valid = 1'b1;
      end
      ACT_CELL: begin
        emit          = h_eff;
        res.cell_end  = h_eff;
        has_data_next = 1'b0;
        mode_next     = MODE_FIELD;
        if (col_count != COL_MAX) col_count_next = col_count + COLUMN_BITS'(1);
      end
      ACT_ROW: begin
        emit           = 1'b1;
        res.cell_end   = h_eff;
        res.row_end    = 1'b1;
        has_data_next  = 1'b0;
        col_count_next = COLUMN_BITS'(1);
        mode_next      = MODE_IDLE;
        if (row_count != ROW_MAX) row_count_next = row_count + ROW_BITS'(1);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      quote_single <= 1'b0;
      delim        <= CH_NUL;
      has_data     <= 1'b0;
      col_count    <= COLUMN_BITS'(1);
      row_count    <= ROW_BITS'(1);
    end else if (row_load.load) begin
      row_count <= ROW_BITS'(row_load.value);
    end else if (accept) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      delim        <= delim_next;
      has_data     <= has_data_next;
      col_count    <= col_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ----- src/dtt_out_reg.sv -----
// result register between parser and output channel
module dtt_out_reg import dtt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  tok_res_t res_in,
  input  logic     out_ready,
  output logic     out_valid,
  output logic     in_ready,
  output tok_res_t res_out
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- src/delimited_text_tokenizer.sv -----
// top level of the delimited text tokenizer
//
// tok_in carries one item per text byte (cmd = 0) or an end-of-input mark
// (cmd = 1). tok_out carries at most one result item per input item: a cell
// content byte, a cell end, or a row end, each tagged with row and column.
// the apb port holds start_row at address 0; writing it also reloads the
// row counter. write it only while the block is idle; the block itself does not enforce this.
// a result appears on tok_out in the cycle after its input item is
// accepted. throughput: one item per cycle while no result stalls, set by the
// state update of the parser feeding one result register.
// tok_in.ready drops only while a result waits in the output register and
// tok_out.ready is low; a stalled result is held there unchanged.
// reset (rst, synchronous) returns the parser to idle between lines,
// forgets the delimiter, sets the column to 1, the row and start_row to 1,
// and empties the output register.
// items that give no result leave tok_out untouched.
module delimited_text_tokenizer import dtt_pkg::*; #(
  parameter int ROW_BITS    = ROW_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dtt_in_if.sink                tok_in,
  dtt_out_if.source             tok_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  row_load_t row_load;
  tok_res_t  res;
  tok_res_t  res_q;
  logic      emit;
  logic      accept;
  logic      in_ready;
  logic      out_valid;

  assign accept       = tok_in.valid && in_ready;
  assign tok_in.ready = in_ready;

  dtt_cfg #(.ROW_BITS(ROW_BITS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .row_load (row_load)
  );

  dtt_parser #(.ROW_BITS(ROW_BITS), .COLUMN_BITS(COLUMN_BITS)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (tok_in.cmd),
    .in_byte  (tok_in.in_byte),
    .row_load (row_load),
    .emit     (emit),
    .res      (res)
  );

  dtt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emit),
    .res_in    (res),
    .out_ready (tok_out.ready),
    .out_valid (out_valid),
    .in_ready  (in_ready),
    .res_out   (res_q)
  );

  assign tok_out.valid      = out_valid;
  assign tok_out.out_byte   = res_q.out_byte;
  assign tok_out.byte_valid = res_q.byte_valid;
  assign tok_out.cell_end   = res_q.cell_end;
  assign tok_out.row_end    = res_q.row_end;
  assign tok_out.row        = res_q.row;
  assign tok_out.column     = res_q.column;

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> tok_out.valid)
    else $error("accepted result not presented");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && !tok_out.ready |-> !tok_in.ready)
    else $error("input taken while result stalled");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && tok_out.byte_valid |-> !tok_out.cell_end && !tok_out.row_end)
    else $error("content byte marked as cell or row end");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid |-> tok_out.byte_valid || tok_out.cell_end || tok_out.row_end)
    else $error("empty result item");

endmodule

// ----- test/tb.sv -----
// testbench of the delimited text tokenizer: random and directed text, checked against a predictor
`timescale 1ns / 100ps

module tb;
  import dtt_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    PM_IDLE   = 3'd0,
    PM_SKIP   = 3'd1,
    PM_FIELD  = 3'd2,
    PM_QUOTED = 3'd3,
    PM_AFTER  = 3'd4
  } parse_mode_e;

  class token_tracker;
    tok_res_t    pending[$];
    int          errors;
    logic [31:0] start_row_q;
    parse_mode_e mode;
    logic        single_q;
    logic [7:0]  sep;
    logic        has_data;
    logic [15:0] col;
    logic [31:0] row;

    function new();
      errors      = 0;
      start_row_q = 32'd1;
      mode        = PM_IDLE;
      single_q    = 1'b0;
      sep         = CH_NUL;
      has_data    = 1'b0;
      col         = 16'd1;
      row         = 32'd1;
    endfunction

    function void load_start_row(logic [31:0] v);
      start_row_q = v;
      row         = v;
    endfunction

    function bit is_sep_candidate(logic [7:0] b);
      return b == CH_COMMA || b == CH_TAB || b == CH_BAR;
    endfunction

    function void push(logic [7:0] b, logic bv, logic ce, logic re);
      tok_res_t t;
      t.out_byte   = b;
      t.byte_valid = bv;
      t.cell_end   = ce;
      t.row_end    = re;
      t.row        = row;
      t.column     = col;
      pending.push_back(t);
    endfunction

    function void store_byte(logic [7:0] b);
      has_data = 1'b1;
      push(b, 1'b1, 1'b0, 1'b0);
    endfunction

    function void finish_cell();
      if (has_data) push(8'h00, 1'b0, 1'b1, 1'b0);
      has_data = 1'b0;
      if (col != 16'hffff) col++;
      mode = PM_FIELD;
    endfunction

    function void finish_row();
      push(8'h00, 1'b0, has_data, 1'b1);
      has_data = 1'b0;
      col      = 16'd1;
      if (row != 32'hffff_ffff) row++;
      mode = PM_IDLE;
    endfunction

    function void field_byte(logic [7:0] b);
      mode = PM_FIELD;
      if (b == CH_CR) return;
      if ((b == CH_DQUOTE || b == CH_SQUOTE) && !has_data) begin
        single_q = (b == CH_SQUOTE);
        mode     = PM_QUOTED;
        return;
      end
      if (sep == CH_NUL && is_sep_candidate(b)) sep = b;
      if (sep != CH_NUL && b == sep) finish_cell();
      else if (b == CH_LF) finish_row();
      else store_byte(b);
    endfunction

    function void take_item(logic c, logic [7:0] b);
      logic [7:0] q;
      if (c == CMD_EOI) begin
        if (mode == PM_FIELD || mode == PM_QUOTED || mode == PM_AFTER) begin
          finish_row();
        end else begin
          mode     = PM_IDLE;
          has_data = 1'b0;
        end
        return;
      end
      case (mode)
        PM_SKIP: begin
          if (b == CH_LF) mode = PM_IDLE;
        end
        PM_FIELD: begin
          field_byte(b);
        end
        PM_QUOTED: begin
          q = single_q ? CH_SQUOTE : CH_DQUOTE;
          if (b != CH_CR) begin
            if (b == q) mode = PM_AFTER;
            else store_byte(b);
          end
        end
        PM_AFTER: begin
          if (b != CH_CR) begin
            if (sep == CH_NUL && is_sep_candidate(b)) begin
              sep = b;
              finish_cell();
            end else if (b == CH_LF) begin
              finish_row();
            end else if (sep != CH_NUL && b == sep) begin
              finish_cell();
            end else begin
              mode = PM_QUOTED;
              store_byte(b);
            end
          end
        end
        default: begin
          mode = PM_IDLE;
          if (b == CH_NUL) begin
            mode = PM_SKIP;
          end else if (b != CH_CR && b != CH_LF) begin
            has_data = 1'b0;
            field_byte(b);
          end
        end
      endcase
    endfunction

    function void check_token(tok_res_t got);
      tok_res_t exp;
      if (pending.size() == 0) begin
        $error("result item with none expected: byte %0h flags %b%b%b row %0d column %0d",
               got.out_byte, got.byte_valid, got.cell_end, got.row_end, got.row, got.column);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== exp.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", exp.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.cell_end !== exp.cell_end) begin
        $error("cell_end: expected %0b, got %0b", exp.cell_end, got.cell_end);
        errors++;
      end
      if (got.row_end !== exp.row_end) begin
        $error("row_end: expected %0b, got %0b", exp.row_end, got.row_end);
        errors++;
      end
      if (got.row !== exp.row) begin
        $error("row: expected %0d, got %0d", exp.row, got.row);
        errors++;
      end
      if (got.column !== exp.column) begin
        $error("column: expected %0d, got %0d", exp.column, got.column);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  dtt_in_if  in_ch ();
  dtt_out_if out_ch ();

  delimited_text_tokenizer uut (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (in_ch),
    .tok_out (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  token_tracker tracker;
  int           cycles;
  int           items_sent;
  bit           in_idle_on;
  bit           out_idle_on;
  int           hold_reqs;
  logic [7:0]   text_sep;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int hold_seen;
    int hold_left;
    int stall_left;
    hold_seen    = 0;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tok_res_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.out_byte   = out_ch.out_byte;
      got.byte_valid = out_ch.byte_valid;
      got.cell_end   = out_ch.cell_end;
      got.row_end    = out_ch.row_end;
      got.row        = out_ch.row;
      got.column     = out_ch.column;
      tracker.check_token(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic c, input logic [7:0] b);
    int gap;
    gap = 0;
    if (in_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tracker.take_item(c, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(CMD_BYTE, b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_start_row(input logic [31:0] want);
    logic [31:0] got;
    apb_read(REG_START_ROW, got);
    if (got !== want) begin
      $error("start_row: expected %0h, got %0h", want, got);
      tracker.errors++;
    end
  endtask

  task automatic set_start_row(input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_START_ROW;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    tracker.load_start_row(v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_start_row(v);
  endtask

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 11))
      0:       return CH_COMMA;
      1:       return CH_TAB;
      2:       return CH_BAR;
      3:       return CH_CR;
      4:       return CH_LF;
      5:       return CH_DQUOTE;
      6:       return CH_SQUOTE;
      7:       return CH_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // cell content that neither splits the cell nor ends the line
  function automatic logic [7:0] plain_char(input bit first);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 2) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(32, 126));
    end while (b == text_sep || b == CH_LF ||
               (first && (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_NUL)));
    return b;
  endfunction

  task automatic send_cell();
    int         n;
    logic [7:0] q;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
      end
      1, 2: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(plain_char(i == 0));
      end
      default: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_byte(q);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0: begin
              send_byte(q);
              send_byte(q);
            end
            1: send_byte(CH_LF);
            2: send_byte(text_sep);
            default: begin
              b = any_char();
              if (b == q) b = 8'h51;
              send_byte(b);
            end
          endcase
        end
        send_byte(q);
        // stray byte after the closing quote
        if ($urandom_range(0, 5) == 0) send_byte(plain_char(1'b0));
      end
    endcase
  endtask

  task automatic send_record();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      send_cell();
      if (i < n - 1) send_byte(text_sep);
    end
    case ($urandom_range(0, 4))
      0: send_item(CMD_EOI, 8'($urandom_range(0, 255)));
      1: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      default: send_byte(CH_LF);
    endcase
  endtask

  task automatic run_random(input int n, input bit idle_ok);
    int stop;
    int pick;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if (idle_ok && $urandom_range(0, 15) == 0) in_idle_on = 1'($urandom_range(0, 1));
      if (idle_ok && $urandom_range(0, 15) == 0) out_idle_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        send_record();
      end else if (pick == 16) begin
        send_byte(CH_LF);
      end else if (pick == 17) begin
        send_byte(CH_NUL);
        send_byte(plain_char(1'b0));
        send_byte(CH_LF);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 9) == 0) send_item(CMD_EOI, 8'($urandom_range(0, 255)));
          else send_byte(any_char());
        end
      end
    end
    send_item(CMD_EOI, 8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  initial begin
    tracker       = new();
    cycles        = 0;
    items_sent    = 0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    hold_reqs     = 0;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.in_byte = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = REG_START_ROW;
    pwdata        = '0;
    case ($urandom_range(0, 2))
      0:       text_sep = CH_COMMA;
      1:       text_sep = CH_TAB;
      default: text_sep = CH_BAR;
    endcase
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_start_row(32'd1);

    // quoted cell with a doubled quote, delimiter first seen after the closing quote
    send_byte(CH_DQUOTE);
    send_byte(8'h61);
    send_byte(CH_DQUOTE);
    send_byte(CH_DQUOTE);
    send_byte(8'h62);
    send_byte(CH_DQUOTE);
    send_byte(text_sep);
    // empty cell, quote and nul inside data, dropped carriage return
    send_byte(text_sep);
    send_byte(8'hff);
    send_byte(CH_DQUOTE);
    send_byte(CH_NUL);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // blank line and a line led by nul
    send_byte(CH_LF);
    send_byte(CH_NUL);
    send_byte(8'h7a);
    send_byte(CH_LF);
    // single quoted cell with newline inside, stray byte, cut off by end of input
    send_byte(CH_SQUOTE);
    send_byte(8'h6d);
    send_byte(CH_LF);
    send_byte(CH_SQUOTE);
    send_byte(8'h7a);
    send_item(CMD_EOI, 8'hff);
    send_item(CMD_EOI, 8'h00);
    wait_drained();

    set_start_row(32'd0);
    hold_reqs++;
    run_random(500, 1'b1);

    // long line of empty cells on a saturated row
    set_start_row(32'hffff_ffff);
    in_idle_on = 1'b0;
    repeat (40) send_byte(text_sep);
    send_byte(8'h41);
    send_byte(text_sep);
    send_byte(8'h42);
    send_byte(CH_LF);
    in_idle_on = 1'b1;
    run_random(450, 1'b1);

    set_start_row(32'hffff_fffd);
    hold_reqs++;
    run_random(500, 1'b1);

    set_start_row($urandom);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_random(350, 1'b0);

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
